### design/rvde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvde_pkg
// Shared types and constants for the RV32I decode/execute unit.
// ----------------------------------------------------------------------------
package rvde_pkg;

    localparam logic [31:0] STOP_WORD = 32'h00c68223;

    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_ALU,
        CLS_JALR,
        CLS_LOAD,
        CLS_STORE,
        CLS_BRANCH,
        CLS_LUI,
        CLS_AUIPC,
        CLS_JAL
    } cls_t;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] instr_pc;
        logic [31:0] src1_value;
        logic [31:0] src2_value;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  dest_index;
        logic        dest_write;
        logic [31:0] dest_value;
        logic [31:0] next_pc;
        logic        redirect;
        logic [1:0]  mem_kind;
        logic [1:0]  mem_size;
        logic        load_unsigned;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        halt;
        logic        illegal;
    } out_item_t;

    // decoded op handed from front to back
    typedef struct packed {
        cls_t        cls;
        logic        halt;
        logic        illegal;
        logic [2:0]  f3;
        logic        alt;
        logic        sub_ok;
        logic [4:0]  rd;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [31:0] a;
        logic [31:0] b;
    } dec_op_t;

endpackage : rvde_pkg
`default_nettype wire

### design/rvde_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvde_front
// Accepts instructions, decodes class and immediate, registers the result.
// ----------------------------------------------------------------------------
module rvde_front
    import rvde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          dq_valid,
    input  wire logic     dq_stall,
    output dec_op_t       dq_data
);

    logic    valid_reg;
    dec_op_t op_reg;
    dec_op_t op_next;
    logic    take;

    logic [31:0] w;
    logic [2:0]  f3;

    assign w  = in_data.instr_word;
    assign f3 = w[14:12];

    always_comb
    begin
        op_next         = '0;
        op_next.f3      = f3;
        op_next.alt     = w[30];
        op_next.rd      = w[11:7];
        op_next.pc      = in_data.instr_pc;
        op_next.a       = in_data.src1_value;
        op_next.b       = in_data.src2_value;
        op_next.cls     = CLS_NONE;
        if (w == STOP_WORD)
        begin
            op_next.halt = 1'b1;
        end
        else
        begin
            case (w[6:0])
                OPC_OP:
                begin
                    op_next.cls    = CLS_ALU;
                    op_next.sub_ok = 1'b1;
                    op_next.imm    = in_data.src2_value;
                end
                OPC_OPIMM:
                begin
                    op_next.cls = CLS_ALU;
                    op_next.imm = {{20{w[31]}}, w[31:20]};
                end
                OPC_JALR:
                begin
                    op_next.cls = CLS_JALR;
                    op_next.imm = {{20{w[31]}}, w[31:20]};
                end
                OPC_LOAD:
                begin
                    op_next.cls     = CLS_LOAD;
                    op_next.imm     = {{20{w[31]}}, w[31:20]};
                    op_next.illegal = (f3 == 3'd3) || (f3 > 3'd5);
                end
                OPC_STORE:
                begin
                    op_next.cls     = CLS_STORE;
                    op_next.imm     = {{20{w[31]}}, w[31:25], w[11:7]};
                    op_next.illegal = (f3 > 3'd2);
                end
                OPC_BRANCH:
                begin
                    op_next.cls     = CLS_BRANCH;
                    op_next.imm     = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                    op_next.illegal = (f3 == 3'd2) || (f3 == 3'd3);
                end
                OPC_LUI:
                begin
                    op_next.cls = CLS_LUI;
                    op_next.imm = {w[31:12], 12'd0};
                end
                OPC_AUIPC:
                begin
                    op_next.cls = CLS_AUIPC;
                    op_next.imm = {w[31:12], 12'd0};
                end
                OPC_JAL:
                begin
                    op_next.cls = CLS_JAL;
                    op_next.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                end
                default:
                begin
                    op_next.illegal = 1'b1;
                end
            endcase
        end
    end

    assign in_stall = valid_reg && dq_stall;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= op_next;
        end
    end

    assign dq_valid = valid_reg;
    assign dq_data  = op_reg;

endmodule : rvde_front
`default_nettype wire

### design/rvde_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvde_queue
// Two-entry queue between decode and execute; full throughput with
// registered stall.
// ----------------------------------------------------------------------------
module rvde_queue
    import rvde_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_valid,
    output logic         wr_stall,
    input  wire dec_op_t wr_data,
    output logic         rd_valid,
    input  wire logic    rd_stall,
    output dec_op_t      rd_data
);

    dec_op_t    mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule : rvde_queue
`default_nettype wire

### design/rvde_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvde_back
// Executes a decoded op: ALU, branch compare, address and target adds.
// Result sits in an output register.
// ----------------------------------------------------------------------------
module rvde_back
    import rvde_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    op_valid,
    output logic         op_stall,
    input  wire dec_op_t op_data,
    output logic         res_valid,
    input  wire logic    res_stall,
    output out_item_t    res_data
);

    logic      valid_reg;
    out_item_t res_reg;
    out_item_t res_next;

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] opb;
    logic [31:0] seq;
    logic [31:0] alu;
    logic [31:0] sum_ai;
    logic [4:0]  sh;
    logic        lt_s;
    logic        lt_u;
    logic        slt_s;
    logic        slt_u;
    logic        cond;

    assign a      = op_data.a;
    assign b      = op_data.b;
    assign opb    = op_data.imm;
    assign sh     = opb[4:0];
    assign seq    = op_data.pc + 32'd4;
    assign sum_ai = a + opb;
    assign lt_s   = $signed(a) < $signed(b);
    assign lt_u   = a < b;
    assign slt_s  = $signed(a) < $signed(opb);
    assign slt_u  = a < opb;

    always_comb
    begin
        case (op_data.f3)
            3'd0:    alu = (op_data.alt && op_data.sub_ok) ? a - opb : sum_ai;
            3'd1:    alu = a << sh;
            3'd2:    alu = {31'd0, slt_s};
            3'd3:    alu = {31'd0, slt_u};
            3'd4:    alu = a ^ opb;
            3'd5:    alu = op_data.alt ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6:    alu = a | opb;
            default: alu = a & opb;
        endcase
    end

    always_comb
    begin
        case (op_data.f3)
            3'd0:    cond = (a == b);
            3'd1:    cond = (a != b);
            3'd4:    cond = lt_s;
            3'd5:    cond = !lt_s;
            3'd6:    cond = lt_u;
            3'd7:    cond = !lt_u;
            default: cond = 1'b0;
        endcase
    end

    always_comb
    begin
        res_next         = '0;
        res_next.next_pc = seq;
        res_next.halt    = op_data.halt;
        res_next.illegal = op_data.illegal;
        if (!op_data.halt && !op_data.illegal)
        begin
            case (op_data.cls)
                CLS_ALU:
                begin
                    res_next.dest_index = op_data.rd;
                    res_next.dest_write = 1'b1;
                    res_next.dest_value = alu;
                end
                CLS_JALR:
                begin
                    res_next.dest_index = op_data.rd;
                    res_next.dest_write = 1'b1;
                    res_next.dest_value = seq;
                    res_next.next_pc    = {sum_ai[31:1], 1'b0};
                    res_next.redirect   = 1'b1;
                end
                CLS_LOAD:
                begin
                    res_next.dest_index    = op_data.rd;
                    res_next.mem_kind      = MEM_LOAD;
                    res_next.mem_size      = op_data.f3[1:0];
                    res_next.load_unsigned = op_data.f3[2];
                    res_next.mem_address   = sum_ai;
                end
                CLS_STORE:
                begin
                    res_next.mem_kind    = MEM_STORE;
                    res_next.mem_size    = op_data.f3[1:0];
                    res_next.mem_address = sum_ai;
                    res_next.store_data  = b;
                end
                CLS_BRANCH:
                begin
                    if (cond)
                    begin
                        res_next.redirect = 1'b1;
                        res_next.next_pc  = op_data.pc + opb;
                    end
                end
                CLS_LUI:
                begin
                    res_next.dest_index = op_data.rd;
                    res_next.dest_write = 1'b1;
                    res_next.dest_value = opb;
                end
                CLS_AUIPC:
                begin
                    res_next.dest_index = op_data.rd;
                    res_next.dest_write = 1'b1;
                    res_next.dest_value = op_data.pc + opb;
                end
                CLS_JAL:
                begin
                    res_next.dest_index = op_data.rd;
                    res_next.dest_write = 1'b1;
                    res_next.dest_value = seq;
                    res_next.next_pc    = op_data.pc + opb;
                    res_next.redirect   = 1'b1;
                end
                default:
                begin
                    res_next.dest_index = 5'd0;
                end
            endcase
            if (op_data.rd == 5'd0)
            begin
                res_next.dest_write = 1'b0;
            end
        end
    end

    assign op_stall = valid_reg && res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!op_stall)
        begin
            valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid && !op_stall)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_data  = res_reg;

endmodule : rvde_back
`default_nettype wire

### design/rv32i_decode_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_decode_execute_unit
// RV32I decode and execute: one instruction in, one result out.
//
// Input channel in_valid/in_stall/in_data carries the instruction word, its
// pc and both source register values. Output channel out_valid/out_stall/
// out_data carries the register write, next pc and redirect, the load or
// store request, and the halt and illegal flags.
// With no stall an instruction passes the decode register, the two-entry
// queue, then the execute result register. Throughput is one instruction
// per cycle while the receiver does not stall.
// Reset clears all valid flags and the queue; no output is presented until
// an instruction has been accepted. When the receiver stalls, the result
// holds, the queue fills, and in_stall rises once decode can no longer move.
// ----------------------------------------------------------------------------
module rv32i_decode_execute_unit
    import rvde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    logic    fq_valid;
    logic    fq_stall;
    dec_op_t fq_data;
    logic    qb_valid;
    logic    qb_stall;
    dec_op_t qb_data;

    rvde_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .dq_valid (fq_valid),
        .dq_stall (fq_stall),
        .dq_data  (fq_data)
    );

    rvde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_data  (qb_data)
    );

    rvde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (qb_valid),
        .op_stall  (qb_stall),
        .op_data   (qb_data),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res_data  (out_data)
    );

endmodule : rv32i_decode_execute_unit
`default_nettype wire

### dv/rv32i_decode_execute_checker.sv
// ----------------------------------------------------------------------------
// rv32i_decode_execute_checker
// Watches both channels of the RV32I decode/execute unit, computes the
// expected result of every accepted instruction and compares each result
// transfer against the oldest expectation.
// ----------------------------------------------------------------------------
module rv32i_decode_execute_checker
    import rvde_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_stall,
    input  wire in_item_t  in_data,
    input  wire logic      out_valid,
    input  wire logic      out_stall,
    input  wire out_item_t out_data,
    output int             fail_count,
    output int             pending_count
);

    out_item_t expected_results[$];

    function automatic logic [31:0] alu_result(logic [2:0] f3, logic alt, logic sub_ok,
                                               logic [31:0] a, logic [31:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            3'd0: return (alt && sub_ok) ? a - b : a + b;
            3'd1: return a << sh;
            3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            3'd3: return (a < b) ? 32'd1 : 32'd0;
            3'd4: return a ^ b;
            3'd5: return alt ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6: return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic out_item_t execute_instr(in_item_t it);
        out_item_t r;
        logic [31:0] w, pc, a, b, seq, imm_i, imm_s, imm_b, imm_j, imm_u;
        logic [2:0] f3;
        logic [4:0] rd;
        logic cond, ill;
        w = it.instr_word; pc = it.instr_pc; a = it.src1_value; b = it.src2_value;
        f3 = w[14:12]; rd = w[11:7];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        imm_u = {w[31:12], 12'd0};
        seq = pc + 32'd4;
        r = '0;
        r.next_pc = seq;
        cond = 1'b0;
        ill = 1'b0;
        if (w == STOP_WORD)
        begin
            r.halt = 1'b1;
            return r;
        end
        case (w[6:0])
            OPC_OP:
            begin
                r.dest_index = rd; r.dest_write = 1'b1;
                r.dest_value = alu_result(f3, w[30], 1'b1, a, b);
            end
            OPC_OPIMM:
            begin
                r.dest_index = rd; r.dest_write = 1'b1;
                r.dest_value = alu_result(f3, w[30], 1'b0, a, imm_i);
            end
            OPC_JALR:
            begin
                r.dest_index = rd; r.dest_write = 1'b1; r.dest_value = seq;
                r.next_pc = (a + imm_i) & ~32'd1;
                r.redirect = 1'b1;
            end
            OPC_LOAD:
            begin
                if (f3 == 3'd3 || f3 > 3'd5)
                    ill = 1'b1;
                else
                begin
                    r.dest_index = rd; r.mem_kind = MEM_LOAD;
                    r.mem_size = f3[1:0]; r.load_unsigned = f3[2];
                    r.mem_address = a + imm_i;
                end
            end
            OPC_STORE:
            begin
                if (f3 > 3'd2)
                    ill = 1'b1;
                else
                begin
                    r.mem_kind = MEM_STORE; r.mem_size = f3[1:0];
                    r.mem_address = a + imm_s; r.store_data = b;
                end
            end
            OPC_BRANCH:
            begin
                case (f3)
                    3'd0: cond = (a == b);
                    3'd1: cond = (a != b);
                    3'd4: cond = $signed(a) < $signed(b);
                    3'd5: cond = !($signed(a) < $signed(b));
                    3'd6: cond = a < b;
                    3'd7: cond = a >= b;
                    default: ill = 1'b1;
                endcase
                if (cond)
                begin
                    r.redirect = 1'b1;
                    r.next_pc = pc + imm_b;
                end
            end
            OPC_LUI:
            begin
                r.dest_index = rd; r.dest_write = 1'b1; r.dest_value = imm_u;
            end
            OPC_AUIPC:
            begin
                r.dest_index = rd; r.dest_write = 1'b1; r.dest_value = pc + imm_u;
            end
            OPC_JAL:
            begin
                r.dest_index = rd; r.dest_write = 1'b1; r.dest_value = seq;
                r.next_pc = pc + imm_j; r.redirect = 1'b1;
            end
            default: ill = 1'b1;
        endcase
        if (ill)
        begin
            r = '0;
            r.next_pc = seq;
            r.illegal = 1'b1;
        end
        if (rd == 5'd0)
            r.dest_write = 1'b0;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk)
    begin
        out_item_t e, g;
        if (rst_n && in_valid && !in_stall)
            expected_results.push_back(execute_instr(in_data));
        if (rst_n && out_valid && !out_stall)
        begin
            g = out_data;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no instruction outstanding");
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("dest_index", 32'(e.dest_index), 32'(g.dest_index));
                check_field("dest_write", 32'(e.dest_write), 32'(g.dest_write));
                check_field("dest_value", e.dest_value, g.dest_value);
                check_field("next_pc", e.next_pc, g.next_pc);
                check_field("redirect", 32'(e.redirect), 32'(g.redirect));
                check_field("mem_kind", 32'(e.mem_kind), 32'(g.mem_kind));
                check_field("mem_size", 32'(e.mem_size), 32'(g.mem_size));
                check_field("load_unsigned", 32'(e.load_unsigned),
                            32'(g.load_unsigned));
                check_field("mem_address", e.mem_address, g.mem_address);
                check_field("store_data", e.store_data, g.store_data);
                check_field("halt", 32'(e.halt), 32'(g.halt));
                check_field("illegal", 32'(e.illegal), 32'(g.illegal));
            end
        end
    end

endmodule

### dv/tb_rv32i_decode_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_rv32i_decode_execute_unit
// Directed and random instruction stream through the decode/execute unit,
// with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_rv32i_decode_execute_unit;
    import rvde_pkg::*;

    localparam int RANDOM_COUNT = 1530;
    localparam int IDLE_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    int        fail_count;
    int        pending_count;
    int        idle_cycles;
    int        sent_count;

    rv32i_decode_execute_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    rv32i_decode_execute_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed encodings of each opcode, some raw noise
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 11))
            0: w[6:0] = OPC_OP;
            1: w[6:0] = OPC_OPIMM;
            2: w[6:0] = OPC_JALR;
            3: w[6:0] = OPC_LOAD;
            4: w[6:0] = OPC_STORE;
            5: w[6:0] = OPC_BRANCH;
            6: w[6:0] = OPC_LUI;
            7: w[6:0] = OPC_AUIPC;
            8: w[6:0] = OPC_JAL;
            9: w = STOP_WORD;
            10: w[6:0] = OPC_BRANCH;
            default: ;
        endcase
        if (w != STOP_WORD && $urandom_range(0, 3) == 0)
            w[31:25] = $urandom_range(0, 1) ? 7'b0100000 : 7'b0000000;
        return w;
    endfunction

    task automatic send_instr(logic [31:0] w, logic [31:0] pc, logic [31:0] a,
                              logic [31:0] b);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (sent_count % 300 < 60)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{instr_word: w, instr_pc: pc, src1_value: a, src2_value: b};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
    endtask

    // receiver stalls
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (($urandom_range(0, 7)) == 0)
                n = 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rv32i_decode_execute_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        sent_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each opcode, extremes and special words
        send_instr(STOP_WORD, 32'hffff_fffc, 32'hffff_ffff, 32'hffff_ffff);
        send_instr(32'h4000_00b3, 32'h0, 32'h0, 32'h1);                // sub x1
        send_instr(32'hfe00_5033, 32'h100, 32'h8000_0000, 32'h1f);   // sra to x0
        send_instr(32'h0000_10b3, 32'h4, 32'hffff_ffff, 32'hffff_ffff); // sll
        send_instr(32'h0000_20b3, 32'h8, 32'h8000_0000, 32'h7fff_ffff); // slt
        send_instr(32'h0000_30b3, 32'hc, 32'h8000_0000, 32'h7fff_ffff); // sltu
        send_instr(32'h4010_5f93, 32'h10, 32'h8000_0000, 32'h0);        // srai
        send_instr(32'hfff0_6f93, 32'h14, 32'h0, 32'h0);                // ori -1
        send_instr(32'h8000_0fe7, 32'hffff_fff0, 32'h7fff_ffff, 32'h0); // jalr
        send_instr(32'hfff5_4f83, 32'h20, 32'h0, 32'h0);                // lbu
        send_instr(32'h0005_3f83, 32'h24, 32'h0, 32'h0);                // illegal load
        send_instr(32'hfef5_2fa3, 32'h28, 32'h1000, 32'hdead_beef);    // sw
        send_instr(32'h0005_3023, 32'h2c, 32'h1000, 32'h1);             // illegal store
        send_instr(32'h0020_8063, 32'h30, 32'h5, 32'h5);                // beq taken
        send_instr(32'hfe20_cfe3, 32'h34, 32'hffff_ffff, 32'h0);        // blt
        send_instr(32'h0020_f063, 32'h38, 32'h0, 32'hffff_ffff);        // bgeu
        send_instr(32'h0020_a063, 32'h3c, 32'h0, 32'h0);                // illegal branch
        send_instr(32'hffff_ffb7, 32'h40, 32'h0, 32'h0);                // lui
        send_instr(32'hffff_f017, 32'h44, 32'h0, 32'h0);                // auipc rd0
        send_instr(32'h8000_00ef, 32'h48, 32'h0, 32'h0);                // jal back
        send_instr(32'h7fff_f0ef, 32'hffff_fffc, 32'h0, 32'h0);         // jal fwd
        send_instr(32'hffff_ffff, 32'h0, 32'h0, 32'h0);                 // unknown
        send_instr(32'h0000_0000, 32'h0, 32'h0, 32'h0);                 // unknown

        // hold off until the pipeline is fully drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);

        for (int i = 0; i < RANDOM_COUNT; i++)
            send_instr(random_instr(), $urandom, pick_operand(), pick_operand());
        in_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d instructions: all opcodes, stop word, illegal encodings,",
                 sent_count);
        $display("random operand extremes, with random sender gaps and receiver stalls.");
        if (fail_count == 0)
            $display("rv32i_decode_execute_unit regression: pass");
        else
            $display("rv32i_decode_execute_unit regression: fail");
        $finish;
    end

endmodule
